FILE: rtl/core/rrbs_pkg.sv
`timescale 1ns / 1ps

package rrbs_pkg;

    // Table size and derived widths
    localparam int MAX_TASK_SLOTS = 128;
    localparam int IDX_W          = $clog2(MAX_TASK_SLOTS);
    localparam int COUNT_W        = $clog2(MAX_TASK_SLOTS + 1);
    localparam int STAT_W         = 3;
    localparam int HANDLE_W       = 7;
    localparam int KEY_W          = 9;
    localparam int TIME_W         = 32;
    localparam int ACT_W          = 3;
    localparam int RES_W          = 2;

    // Task status codes
    localparam logic [STAT_W-1:0] ST_READY      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXITED     = 3'd1;
    localparam logic [STAT_W-1:0] ST_WAIT_TASK  = 3'd2;
    localparam logic [STAT_W-1:0] ST_WAIT_INPUT = 3'd3;
    localparam logic [STAT_W-1:0] ST_SLEEPING   = 3'd4;
    localparam logic [STAT_W-1:0] ST_RUNNING    = 3'd5;
    localparam logic [STAT_W-1:0] ST_UNUSED     = 3'd6;

    // Event codes
    localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_EXIT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WAIT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SLEEP  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RETRY  = 3'd5;

    // Result status codes
    localparam logic [RES_W-1:0] RES_OK   = 2'd0;
    localparam logic [RES_W-1:0] RES_IDLE = 2'd1;
    localparam logic [RES_W-1:0] RES_FULL = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [HANDLE_W-1:0] target_task;
        logic [TIME_W-1:0]   sleep_ms;
        logic [TIME_W-1:0]   now_ms;
        logic                key_available;
        logic [KEY_W-1:0]    key_code;
    } t_in_item;

    typedef struct packed {
        logic [RES_W-1:0]    status;
        logic [HANDLE_W-1:0] running_task;
        logic [HANDLE_W-1:0] new_handle;
        logic                key_valid;
        logic [KEY_W-1:0]    key_value;
    } t_out_item;

    // Broadcast write into one slot
    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    idx;
        logic [STAT_W-1:0]   status;
        logic                we_wake;
        logic [TIME_W-1:0]   wake;
        logic                we_awaited;
        logic [HANDLE_W-1:0] awaited;
    } t_cell_wr;

    // Scan token control
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] start;
        logic             adv;
    } t_tok_ctl;

    // What a slot shows to the scheduler; sel_* are zero unless the slot holds the token
    typedef struct packed {
        logic                tok;
        logic                tok_fwd;
        logic                tok_wrap;
        logic [IDX_W-1:0]    sel_idx;
        logic [STAT_W-1:0]   sel_status;
        logic [TIME_W-1:0]   sel_wake;
        logic [HANDLE_W-1:0] sel_awaited;
        logic                exited;
        logic                running;
    } t_cell_obs;

endpackage

FILE: rtl/core/rrbs_cell.sv
`timescale 1ns / 1ps

module rrbs_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rrbs_pkg::IDX_W-1:0]    i_idx,
    input  logic [rrbs_pkg::COUNT_W-1:0]  i_count,
    input  rrbs_pkg::t_cell_wr            i_wr,
    input  rrbs_pkg::t_tok_ctl            i_tok_ctl,
    input  logic                          i_tok_in,
    output rrbs_pkg::t_cell_obs           o_obs
);

    logic [rrbs_pkg::STAT_W-1:0]   r_status;
    logic [rrbs_pkg::TIME_W-1:0]   r_wake;
    logic [rrbs_pkg::HANDLE_W-1:0] r_awaited;
    logic                          r_tok;
    logic                          w_hit;
    logic                          w_last;

    assign w_hit  = i_wr.we && (i_wr.idx == i_idx);
    assign w_last = (rrbs_pkg::COUNT_W'(i_idx) == (i_count - rrbs_pkg::COUNT_W'(1)));

    // Status and token: slot 0 starts ready, the rest unused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= (i_idx == '0) ? rrbs_pkg::ST_READY : rrbs_pkg::ST_UNUSED;
            r_tok    <= 1'b0;
        end else begin
            if (w_hit) begin
                r_status <= i_wr.status;
            end
            if (i_tok_ctl.load) begin
                r_tok <= (i_idx == i_tok_ctl.start);
            end else if (i_tok_ctl.adv) begin
                r_tok <= i_tok_in;
            end
        end
    end

    // Wake time and awaited handle, written on demand
    always_ff @(posedge i_clk) begin
        if (w_hit && i_wr.we_wake) begin
            r_wake <= i_wr.wake;
        end
        if (w_hit && i_wr.we_awaited) begin
            r_awaited <= i_wr.awaited;
        end
    end

    // Token leaves the last used slot through the wrap path
    always_comb begin
        o_obs.tok         = r_tok;
        o_obs.tok_fwd     = r_tok && !w_last;
        o_obs.tok_wrap    = r_tok && w_last;
        o_obs.sel_idx     = r_tok ? i_idx : '0;
        o_obs.sel_status  = r_tok ? r_status : '0;
        o_obs.sel_wake    = r_tok ? r_wake : '0;
        o_obs.sel_awaited = r_tok ? r_awaited : '0;
        o_obs.exited      = (r_status == rrbs_pkg::ST_EXITED);
        o_obs.running     = (r_status == rrbs_pkg::ST_RUNNING);
    end

endmodule

FILE: rtl/core/round_robin_blocking_task_scheduler.sv
`timescale 1ns / 1ps

// Round-robin task scheduler over a chain of task slots, one event per transaction.
// Create, a read with a key pending and a retry while the current task runs skip the
// scan. Other events start a scan: a token walks the slot chain one slot per cycle,
// starting after the current task and ending on it, so it visits up to task_count
// slots (128 at most). A new event is accepted once the previous result has moved
// into the output register, so one result may wait there while the next event is
// being scheduled.
module round_robin_blocking_task_scheduler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rrbs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rrbs_pkg::t_out_item o_out_data
);

    localparam int MAX = rrbs_pkg::MAX_TASK_SLOTS;
    localparam int IW  = rrbs_pkg::IDX_W;
    localparam int CW  = rrbs_pkg::COUNT_W;
    localparam int CMP_W = IW + 8;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [IW-1:0]               r_cur, n_cur;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_steps, n_steps;
    logic [rrbs_pkg::TIME_W-1:0] r_now, n_now;
    logic                        r_key_av, n_key_av;
    logic [rrbs_pkg::KEY_W-1:0]  r_key, n_key;
    rrbs_pkg::t_out_item         r_res, n_res;
    rrbs_pkg::t_out_item         r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    rrbs_pkg::t_cell_wr          w_wr;
    rrbs_pkg::t_tok_ctl          w_tok;
    rrbs_pkg::t_cell_obs         w_obs [MAX];
    logic [MAX-1:0]              w_tok_vec;
    logic [MAX-1:0]              w_exit_vec;
    logic [MAX-1:0]              w_run_vec;
    logic                        w_wrap;
    logic [IW-1:0]               w_sel_idx;
    logic [rrbs_pkg::STAT_W-1:0] w_sel_status;
    logic [rrbs_pkg::TIME_W-1:0] w_sel_wake;
    logic [rrbs_pkg::HANDLE_W-1:0] w_sel_awaited;
    logic [rrbs_pkg::TIME_W-1:0] w_diff;
    logic                        w_later;
    logic [CMP_W-1:0]            w_t_ext;
    logic                        w_t_done;
    logic                        w_pick;
    logic [CW-1:0]               w_cur_inc;
    logic [IW-1:0]               w_start;
    logic                        w_accept;
    logic                        w_out_free;

    // Slot chain
    for (genvar g = 0; g < MAX; g++) begin : g_cell
        rrbs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (IW'(g)),
            .i_count   (r_count),
            .i_wr      (w_wr),
            .i_tok_ctl (w_tok),
            .i_tok_in  ((g == 0) ? w_wrap : w_obs[(g == 0) ? 0 : g - 1].tok_fwd),
            .o_obs     (w_obs[g])
        );
    end

    // Gather the token holder's view
    always_comb begin
        w_wrap        = 1'b0;
        w_sel_idx     = '0;
        w_sel_status  = '0;
        w_sel_wake    = '0;
        w_sel_awaited = '0;
        for (int k = 0; k < MAX; k++) begin
            w_tok_vec[k]  = w_obs[k].tok;
            w_exit_vec[k] = w_obs[k].exited;
            w_run_vec[k]  = w_obs[k].running;
            w_wrap        = w_wrap | w_obs[k].tok_wrap;
            w_sel_idx     = w_sel_idx | w_obs[k].sel_idx;
            w_sel_status  = w_sel_status | w_obs[k].sel_status;
            w_sel_wake    = w_sel_wake | w_obs[k].sel_wake;
            w_sel_awaited = w_sel_awaited | w_obs[k].sel_awaited;
        end
    end

    // Runnable test for the slot under the token
    assign w_diff   = r_now - w_sel_wake;
    assign w_later  = (w_diff != '0) && !w_diff[rrbs_pkg::TIME_W-1];
    assign w_t_ext  = CMP_W'(w_sel_awaited);
    assign w_t_done = (w_t_ext < CMP_W'(MAX)) && w_exit_vec[w_t_ext[IW-1:0]];

    always_comb begin
        case (w_sel_status)
            rrbs_pkg::ST_READY:      w_pick = 1'b1;
            rrbs_pkg::ST_SLEEPING:   w_pick = w_later;
            rrbs_pkg::ST_WAIT_TASK:  w_pick = w_t_done;
            rrbs_pkg::ST_WAIT_INPUT: w_pick = r_key_av;
            default:                 w_pick = 1'b0;
        endcase
    end

    assign w_cur_inc  = CW'(r_cur) + CW'(1);
    assign w_start    = (w_cur_inc == r_count) ? '0 : IW'(w_cur_inc);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Event handling and scan control
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_count     = r_count;
        n_steps     = r_steps;
        n_now       = r_now;
        n_key_av    = r_key_av;
        n_key       = r_key;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_wr        = '0;
        w_tok       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res              = '0;
                    n_res.running_task = rrbs_pkg::HANDLE_W'(r_cur);
                    n_now              = i_in_data.now_ms;
                    n_key_av           = i_in_data.key_available;
                    n_key              = i_in_data.key_code;
                    n_steps            = '0;
                    w_tok.start        = w_start;
                    w_wr.idx           = r_cur;
                    n_state            = S_SCAN;
                    case (i_in_data.action)
                        rrbs_pkg::ACT_CREATE: begin
                            n_state = S_DONE;
                            if (r_count >= CW'(MAX)) begin
                                n_res.status = rrbs_pkg::RES_FULL;
                            end else begin
                                n_res.new_handle = rrbs_pkg::HANDLE_W'(r_count);
                                w_wr.we          = 1'b1;
                                w_wr.idx         = IW'(r_count);
                                w_wr.status      = rrbs_pkg::ST_READY;
                                n_count          = r_count + CW'(1);
                            end
                        end
                        rrbs_pkg::ACT_EXIT: begin
                            w_wr.we     = 1'b1;
                            w_wr.status = rrbs_pkg::ST_EXITED;
                        end
                        rrbs_pkg::ACT_WAIT: begin
                            w_wr.we         = 1'b1;
                            w_wr.status     = rrbs_pkg::ST_WAIT_TASK;
                            w_wr.we_awaited = 1'b1;
                            w_wr.awaited    = i_in_data.target_task;
                        end
                        rrbs_pkg::ACT_SLEEP: begin
                            w_wr.we      = 1'b1;
                            w_wr.status  = rrbs_pkg::ST_SLEEPING;
                            w_wr.we_wake = 1'b1;
                            w_wr.wake    = i_in_data.now_ms + i_in_data.sleep_ms;
                        end
                        rrbs_pkg::ACT_READ: begin
                            if (i_in_data.key_available) begin
                                n_res.key_valid = 1'b1;
                                n_res.key_value = i_in_data.key_code;
                                n_state         = S_DONE;
                            end else begin
                                w_wr.we     = 1'b1;
                                w_wr.status = rrbs_pkg::ST_WAIT_INPUT;
                            end
                        end
                        default: begin
                            // retry and undefined codes
                            if (w_run_vec[r_cur]) begin
                                n_state = S_DONE;
                            end
                        end
                    endcase
                    w_tok.load = (n_state == S_SCAN);
                end
            end
            S_SCAN: begin
                if (w_pick) begin
                    w_wr.we            = 1'b1;
                    w_wr.idx           = w_sel_idx;
                    w_wr.status        = rrbs_pkg::ST_RUNNING;
                    n_cur              = w_sel_idx;
                    n_res.status       = rrbs_pkg::RES_OK;
                    n_res.running_task = rrbs_pkg::HANDLE_W'(w_sel_idx);
                    if (w_sel_status == rrbs_pkg::ST_WAIT_INPUT) begin
                        n_res.key_valid = 1'b1;
                        n_res.key_value = r_key;
                    end
                    n_state = S_DONE;
                end else if (r_steps == (r_count - CW'(1))) begin
                    n_res.status = rrbs_pkg::RES_IDLE;
                    n_state      = S_DONE;
                end else begin
                    w_tok.adv = 1'b1;
                    n_steps   = r_steps + CW'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_count     <= CW'(1);
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_count     <= n_count;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_now    <= n_now;
        r_key_av <= n_key_av;
        r_key    <= n_key;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_tok_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec))
        else $error("more than one slot holds the scan token");

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> $onehot(w_tok_vec))
        else $error("scan running without a token");

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_steps < r_count))
        else $error("scan went past the task count");

    a_cur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_cur) < r_count)
        else $error("current task outside the used slots");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX)))
        else $error("task count out of range");

endmodule
